FILE: hw/rtl/apt_pkg.sv
// Shared types and constants for the affine point transform.
`default_nettype none

package apt_pkg;

    // Width of one Q-format coordinate or coefficient.
    localparam int Q_W        = 32;
    // Width of one full-precision product.
    localparam int PROD_W     = 2 * Q_W;
    // Three products plus an aligned translation need two guard bits.
    localparam int SUM_W      = PROD_W + 2;
    // Number of output components.
    localparam int NUM_AXES   = 3;

    // Configuration port geometry: six 64-bit registers at 8-byte spacing.
    localparam int CFG_NUM_REGS = 6;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_IDX_LSB  = 3;

    typedef logic signed [Q_W-1:0]   t_q;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [CFG_DATA_W-1:0]   t_cfg_word;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X_FIRST  = 3'd0,
        REG_ROW_X_SECOND = 3'd1,
        REG_ROW_Y_FIRST  = 3'd2,
        REG_ROW_Y_SECOND = 3'd3,
        REG_ROW_Z_FIRST  = 3'd4,
        REG_ROW_Z_SECOND = 3'd5
    } t_cfg_reg;

    // Coefficients of one matrix row as seen by one lane.
    typedef struct packed {
        t_q coef_x;
        t_q coef_y;
        t_q coef_z;
        t_q trans;
    } t_row_coef;

    // Per-stage load enables from the pipeline control.
    typedef struct packed {
        logic ld_mul;
        logic ld_add;
        logic ld_sat;
    } t_pipe_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/apt_if.sv
// Point and result stream interfaces for the affine point transform.
`default_nettype none

interface apt_point_if;
    import apt_pkg::*;

    logic valid;
    logic ready;
    t_q   point_x;
    t_q   point_y;
    t_q   point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface apt_result_if;
    import apt_pkg::*;

    logic valid;
    logic ready;
    t_q   result_x;
    t_q   result_y;
    t_q   result_z;
    logic clipped;

    modport source (output valid, output result_x, output result_y, output result_z,
                    output clipped, input ready);
    modport sink   (input valid, input result_x, input result_y, input result_z,
                    input clipped, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/affine_point_transform.sv
// Top level of the affine point transform: config registers, control and three lanes.
`default_nettype none

// Transforms a stream of 3D points (x, y, z) by a 4x4 affine matrix held in
// six 64-bit configuration registers, with the bottom row taken as 0 0 0 1.
// Each output component is the exact sum of three full-precision products and
// the aligned translation, shifted right by FRAC_BITS (rounding towards minus
// infinity) and saturated to signed 32 bits; clipped is set when any component
// was saturated. The block accepts one item every cycle unless a result-side
// stall has filled all stages; each item passes through the three register
// stages of each lane: multiply, sum, then shift and saturate. A stall on the
// result side ripples back stage by stage, so bubbles are squeezed out and an
// item is taken whenever any stage is free. After reset the matrix is the
// identity. Registers sit at byte addresses 0, 8, ... 40; the low half of each
// holds the first coefficient of the pair and the high half the second. The
// matrix should only be rewritten while no item is in flight.

module affine_point_transform
    import apt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    apt_point_if.sink                  i_point,
    apt_result_if.source               o_result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire t_cfg_word             pwdata,
    output t_cfg_word                  prdata,
    output logic                       pready
);

    t_row_coef w_rows [NUM_AXES];
    t_pipe_ctl w_ctl;
    t_q        w_res  [NUM_AXES];
    logic      w_clip [NUM_AXES];

    apt_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rows  (w_rows)
    );

    apt_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_point.valid),
        .o_in_ready  (i_point.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_ctl       (w_ctl)
    );

    // One lane per output component; all share the same point and enables.
    for (genvar r = 0; r < NUM_AXES; r++) begin : g_lane
        apt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_coef   (w_rows[r]),
            .i_x      (i_point.point_x),
            .i_y      (i_point.point_y),
            .i_z      (i_point.point_z),
            .o_result (w_res[r]),
            .o_clip   (w_clip[r])
        );
    end

    assign o_result.result_x = w_res[0];
    assign o_result.result_y = w_res[1];
    assign o_result.result_z = w_res[2];
    assign o_result.clipped  = w_clip[0] || w_clip[1] || w_clip[2];

endmodule

`default_nettype wire

FILE: hw/rtl/apt_cfg_regs.sv
// Matrix coefficient registers behind the APB-style configuration port.
`default_nettype none

module apt_cfg_regs
    import apt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire t_cfg_word             pwdata,
    output t_cfg_word                  prdata,
    output logic                       pready,
    output t_row_coef                  o_rows [NUM_AXES]
);

    // The value 1.0 in the chosen fixed-point format.
    localparam t_cfg_word ONE = t_cfg_word'(1) << FRAC_BITS;

    t_cfg_word r_regs [CFG_NUM_REGS];
    t_cfg_idx  w_idx;
    logic      w_wr;

    assign w_idx  = paddr[CFG_IDX_LSB +: CFG_IDX_W];
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[REG_ROW_X_FIRST]  <= ONE;
            r_regs[REG_ROW_X_SECOND] <= '0;
            r_regs[REG_ROW_Y_FIRST]  <= ONE << Q_W;
            r_regs[REG_ROW_Y_SECOND] <= '0;
            r_regs[REG_ROW_Z_FIRST]  <= '0;
            r_regs[REG_ROW_Z_SECOND] <= ONE;
        end else if (w_wr && (int'(w_idx) < CFG_NUM_REGS)) begin
            r_regs[w_idx] <= pwdata;
        end
    end

    always_comb begin
        if (int'(w_idx) < CFG_NUM_REGS) begin
            prdata = r_regs[w_idx];
        end else begin
            prdata = '0;
        end
    end

    // Each row owns a pair of registers: the first holds the x and y
    // coefficients, the second the z coefficient and the translation.
    for (genvar r = 0; r < NUM_AXES; r++) begin : g_row
        assign o_rows[r].coef_x = t_q'(r_regs[2*r][Q_W-1:0]);
        assign o_rows[r].coef_y = t_q'(r_regs[2*r][CFG_DATA_W-1:Q_W]);
        assign o_rows[r].coef_z = t_q'(r_regs[2*r+1][Q_W-1:0]);
        assign o_rows[r].trans  = t_q'(r_regs[2*r+1][CFG_DATA_W-1:Q_W]);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/apt_lane.sv
// One output component: multiply, accumulate, then shift and saturate.
`default_nettype none

module apt_lane
    import apt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire t_pipe_ctl i_ctl,
    input  wire t_row_coef i_coef,
    input  wire t_q        i_x,
    input  wire t_q        i_y,
    input  wire t_q        i_z,
    output t_q             o_result,
    output logic           o_clip
);

    t_prod r_prod_x, r_prod_y, r_prod_z;
    t_sum  r_sum;
    t_q    r_result;
    logic  r_clip;

    t_prod n_prod_x, n_prod_y, n_prod_z;
    t_sum  n_sum;
    t_sum  w_shift;
    logic  w_over, w_under;
    t_q    n_result;

    // Stage one: three full-precision products.
    assign n_prod_x = i_coef.coef_x * i_x;
    assign n_prod_y = i_coef.coef_y * i_y;
    assign n_prod_z = i_coef.coef_z * i_z;

    // Stage two: exact sum with the translation aligned to product scale.
    assign n_sum = SUM_W'(r_prod_x) + SUM_W'(r_prod_y) + SUM_W'(r_prod_z)
                 + (SUM_W'(i_coef.trans) <<< FRAC_BITS);

    // Stage three: floor shift, then clamp to 32 bits.
    always_comb begin
        w_shift = r_sum >>> FRAC_BITS;
        w_over  = !w_shift[SUM_W-1] && (|w_shift[SUM_W-2:Q_W-1]);
        w_under = w_shift[SUM_W-1] && !(&w_shift[SUM_W-2:Q_W-1]);
        if (w_over) begin
            n_result = {1'b0, {(Q_W-1){1'b1}}};
        end else if (w_under) begin
            n_result = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            n_result = t_q'(w_shift[Q_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_prod_z <= n_prod_z;
        end
        if (i_ctl.ld_add) begin
            r_sum <= n_sum;
        end
        if (i_ctl.ld_sat) begin
            r_result <= n_result;
            r_clip   <= w_over || w_under;
        end
    end

    assign o_result = r_result;
    assign o_clip   = r_clip;

endmodule

`default_nettype wire

FILE: hw/rtl/apt_pipe_ctrl.sv
// Valid tracking and stall control for the three-stage datapath.
`default_nettype none

module apt_pipe_ctrl
    import apt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic r_vld_mul, r_vld_add, r_vld_sat;
    logic w_adv_mul, w_adv_add, w_adv_sat;

    // A stage moves on when it is empty or the stage after it moves on.
    assign w_adv_sat = !r_vld_sat || i_out_ready;
    assign w_adv_add = !r_vld_add || w_adv_sat;
    assign w_adv_mul = !r_vld_mul || w_adv_add;

    assign o_ctl.ld_mul = w_adv_mul;
    assign o_ctl.ld_add = w_adv_add;
    assign o_ctl.ld_sat = w_adv_sat;
    assign o_in_ready   = w_adv_mul;
    assign o_out_valid  = r_vld_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_mul <= 1'b0;
            r_vld_add <= 1'b0;
            r_vld_sat <= 1'b0;
        end else begin
            if (w_adv_mul) begin
                r_vld_mul <= i_in_valid;
            end
            if (w_adv_add) begin
                r_vld_add <= r_vld_mul;
            end
            if (w_adv_sat) begin
                r_vld_sat <= r_vld_add;
            end
        end
    end

`ifndef SYNTHESIS
    a_full_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_mul && r_vld_add && r_vld_sat && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while every stage is full and stalled");

    a_bubble_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld_mul || !r_vld_add || !r_vld_sat) |-> o_in_ready)
        else $error("input refused although the pipeline holds a bubble");

    a_item_moves_to_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_add && w_adv_sat) |=> r_vld_sat)
        else $error("item lost between the add and saturate stages");

    a_stalled_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_mul && !w_adv_add) |=> r_vld_mul)
        else $error("stalled item dropped from the multiply stage");
`endif

endmodule

`default_nettype wire
